// ===== rtl/mesf_pkg.sv =====
// Package for the matrix extremum and saddle finder.
// Holds the item types, the register and result codes and the axis compare.
// No dependencies; every other file of the block but mesf_ram imports it.
package mesf_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int DEFAULT_MAX_COLS = 64;
  localparam int DEFAULT_Q_DEPTH  = 2;
  localparam int CFG_BITS         = 7;
  localparam int ROW_BITS         = 7;
  localparam int POS_BITS         = 6;
  localparam int ROW_LIMIT        = 64;
  localparam int MIN_DIM          = 3;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_COLS = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_ROWS = 1'b1;

  localparam logic [1:0] KIND_MAX    = 2'd0;
  localparam logic [1:0] KIND_MIN    = 2'd1;
  localparam logic [1:0] KIND_SADDLE = 2'd2;

  localparam logic [1:0] AX_NONE = 2'd0;
  localparam logic [1:0] AX_HIGH = 2'd1;
  localparam logic [1:0] AX_LOW  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [POS_BITS-1:0]           row;
    logic [POS_BITS-1:0]           col;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] up;
    logic signed [SAMPLE_BITS-1:0] mid;
    logic                          examine;
    logic [POS_BITS-1:0]           row;
    logic [POS_BITS-1:0]           col;
  } queue_item_t;

  function automatic logic [1:0] axis_class(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b,
    input logic signed [SAMPLE_BITS-1:0] c
  );
    logic [1:0] res;
    res = AX_NONE;
    if (b > a && b > c) begin
      res = AX_HIGH;
    end else if (b < a && b < c) begin
      res = AX_LOW;
    end
    return res;
  endfunction

endpackage

// ===== rtl/mesf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the line stores.
module mesf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mesf_front.sv =====
// Front part: raster position tracking, frame limits and line store access.
// Depends on mesf_pkg and mesf_ram; feeds the queue with window column data.
module mesf_front import mesf_pkg::*; #(
  parameter int MAX_COLS = DEFAULT_MAX_COLS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  input  logic [CFG_BITS-1:0] frame_cols_i,
  input  logic [CFG_BITS-1:0] frame_rows_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output queue_item_t         q_data_o
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int NW   = $clog2(MAX_COLS + 1);
  localparam int CMPW = (NW > CFG_BITS) ? NW : CFG_BITS;

  logic [ROW_BITS-1:0] row_q, row_d;
  logic [CW-1:0]       col_q, col_d;

  logic                          s1_valid_q, s1_valid_d;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [POS_BITS-1:0]           s1_row_q;
  logic [CW-1:0]                 s1_col_q;

  logic [CMPW-1:0]     cols_ext, cols_w, col0, col1, col_next;
  logic [ROW_BITS-1:0] rows_w, row0, row1;
  logic                accept, skip, wrap1, rd_en, wr_en;
  logic [2*SAMPLE_BITS-1:0] rd_data, wr_data;

  always_comb begin
    cols_ext = CMPW'(frame_cols_i);
    if (cols_ext < CMPW'(MIN_DIM)) begin
      cols_w = CMPW'(MIN_DIM);
    end else if (cols_ext > CMPW'(MAX_COLS)) begin
      cols_w = CMPW'(MAX_COLS);
    end else begin
      cols_w = cols_ext;
    end
    if (frame_rows_i < ROW_BITS'(MIN_DIM)) begin
      rows_w = ROW_BITS'(MIN_DIM);
    end else if (frame_rows_i > ROW_BITS'(ROW_LIMIT)) begin
      rows_w = ROW_BITS'(ROW_LIMIT);
    end else begin
      rows_w = frame_rows_i;
    end
  end

  assign in_ready_o = !s1_valid_q || q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col0 = in_data_i.frame_start ? '0 : CMPW'(col_q);
    row0 = in_data_i.frame_start ? '0 : row_q;
    col1 = col0;
    row1 = row0;
    if (col0 >= cols_w) begin
      col1 = '0;
      if (row0 < rows_w) begin
        row1 = row0 + ROW_BITS'(1);
      end
    end
    skip     = row1 >= rows_w;
    col_next = col1 + CMPW'(1);
    wrap1    = col_next >= cols_w;

    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (skip) begin
        row_d = rows_w;
        col_d = CW'(col1);
      end else if (wrap1) begin
        row_d = row1 + ROW_BITS'(1);
        col_d = '0;
      end else begin
        row_d = row1;
        col_d = CW'(col_next);
      end
    end
  end

  assign rd_en = accept && !skip;
  assign wr_en = s1_valid_q && q_ready_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = rd_en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_sample_q <= in_data_i.sample;
      s1_row_q    <= POS_BITS'(row1);
      s1_col_q    <= CW'(col1);
    end
  end

  // Each entry holds the upper line in the high half and the middle line in the low half.
  assign wr_data = {rd_data[SAMPLE_BITS-1:0], s1_sample_q};

  mesf_ram #(
    .WIDTH(2 * SAMPLE_BITS),
    .DEPTH(MAX_COLS)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_col_q),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(CW'(col1)),
    .rdata_o(rd_data)
  );

  always_comb begin
    q_data_o.sample  = s1_sample_q;
    q_data_o.up      = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    q_data_o.mid     = rd_data[SAMPLE_BITS-1:0];
    q_data_o.examine = (s1_row_q >= POS_BITS'(2)) && (s1_col_q >= CW'(2));
    q_data_o.row     = s1_row_q - POS_BITS'(1);
    q_data_o.col     = POS_BITS'(s1_col_q - CW'(1));
  end

  assign q_valid_o = s1_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_BITS'(ROW_LIMIT))
    else $error("Row position beyond the row limit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !q_ready_i |=> s1_valid_q && $stable(s1_col_q) && !$past(in_ready_o))
    else $error("Stalled line store access lost or overwritten.");

endmodule

// ===== rtl/mesf_fifo.sv =====
// Short queue between the front and back parts.
// Depends on mesf_pkg for the queue item type.
module mesf_fifo import mesf_pkg::*; #(
  parameter int DEPTH = DEFAULT_Q_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  queue_item_t push_data_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output queue_item_t pop_data_o
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  queue_item_t    mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNW-1:0] count_q, count_d;
  logic           push, pop;

  assign push_ready_o = count_q != CNW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mesf_back.sv =====
// Back part: window registers, neighbor compares and the result register.
// Depends on mesf_pkg; takes queue items and drives the result channel.
module mesf_back import mesf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  queue_item_t q_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  logic signed [SAMPLE_BITS-1:0] mid_left_q, mid_centre_q, up_centre_q, below_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic [1:0] h_cls, v_cls;
  logic       pop, hit;

  assign q_ready_o = !out_valid_q || out_ready_i;
  assign pop       = q_valid_i && q_ready_o;

  always_comb begin
    h_cls = axis_class(mid_left_q, mid_centre_q, q_data_i.mid);
    v_cls = axis_class(up_centre_q, mid_centre_q, below_q);
    hit   = q_data_i.examine && (h_cls != AX_NONE) && (v_cls != AX_NONE);

    if (h_cls == AX_HIGH && v_cls == AX_HIGH) begin
      out_d.kind = KIND_MAX;
    end else if (h_cls == AX_LOW && v_cls == AX_LOW) begin
      out_d.kind = KIND_MIN;
    end else begin
      out_d.kind = KIND_SADDLE;
    end
    out_d.value = mid_centre_q;
    out_d.row   = q_data_i.row;
    out_d.col   = q_data_i.col;

    out_valid_d = out_valid_q;
    if (q_ready_o) begin
      out_valid_d = pop && hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      mid_left_q   <= '0;
      mid_centre_q <= '0;
      up_centre_q  <= '0;
      below_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        mid_left_q   <= mid_centre_q;
        mid_centre_q <= q_data_i.mid;
        up_centre_q  <= q_data_i.up;
        below_q      <= q_data_i.sample;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && hit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.kind == KIND_MAX || out_q.kind == KIND_MIN ||
                     out_q.kind == KIND_SADDLE))
    else $error("Result item carries an undefined kind.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.row != '0)
    else $error("Result item reports a border row.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop) && $past(q_data_i.examine))
    else $error("Result item without an examined queue item.");

endmodule

// ===== rtl/matrix_extremum_saddle_finder_unit.sv =====
// Top level of the matrix extremum and saddle finder.
// Depends on mesf_pkg, mesf_front, mesf_fifo and mesf_back; holds the registers.
//
// The block takes one matrix element per clock in raster order unless the output stalls,
// and reports each interior element that is a strict local maximum, local minimum or
// saddle point on its row and column axes, with its value and position. The element at
// (r-1, c-1) is decided once (r, c) is accepted; its result passes the front stage, the
// queue and the result register. The line store RAM, read once per item and written back
// when the queue takes it, sets the rate. The line stores have no reset or clearing pass,
// so the block is ready right after reset. Rows and columns are clamped to 3..64 and
// 3..MAX_COLS; elements past the last row are dropped until the next frame start.
// Registers are to be written only while the block is idle; this is not enforced.
module matrix_extremum_saddle_finder_unit import mesf_pkg::*; #(
  parameter int MAX_COLS = DEFAULT_MAX_COLS,
  parameter int Q_DEPTH  = DEFAULT_Q_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  in_item_t                  in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output out_item_t                 out_data_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]       cfg_data_i
);

  logic [CFG_BITS-1:0] frame_cols_q, frame_cols_d, frame_rows_q, frame_rows_d;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  queue_item_t fq_data, bq_data;

  always_comb begin
    frame_cols_d = frame_cols_q;
    frame_rows_d = frame_rows_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_COLS: frame_cols_d = cfg_data_i;
        CFG_FRAME_ROWS: frame_rows_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cols_q <= CFG_BITS'(8);
      frame_rows_q <= CFG_BITS'(8);
    end else begin
      frame_cols_q <= frame_cols_d;
      frame_rows_q <= frame_rows_d;
    end
  end

  mesf_front #(
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .frame_cols_i(frame_cols_q),
    .frame_rows_i(frame_rows_q),
    .q_valid_o   (fq_valid),
    .q_ready_i   (fq_ready),
    .q_data_o    (fq_data)
  );

  mesf_fifo #(
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i (fq_data),
    .pop_valid_o (bq_valid),
    .pop_ready_i (bq_ready),
    .pop_data_o  (bq_data)
  );

  mesf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (bq_valid),
    .q_ready_o  (bq_ready),
    .q_data_i   (bq_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
